>>> sv/esw_pkg.sv
package esw_pkg;

   // default edge capacity
   localparam int MaxEdgesDefault = 32;

   // input beat
   typedef struct packed {
      logic [7:0]         source_vertex;
      logic [7:0]         dest_vertex;
      logic signed [15:0] edge_weight;
      logic               is_last;
   } req_type;

   // result beat
   typedef struct packed {
      logic [7:0]         out_source;
      logic [7:0]         out_dest;
      logic signed [15:0] out_weight;
      logic               out_last;
      logic               overflowed;
   } rsp_type;

   // one stored edge
   typedef struct packed {
      logic [7:0]         src;
      logic [7:0]         dst;
      logic signed [15:0] weight;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic insert;
      logic set_ovf;
      logic pop;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic full;
      logic has_entry;
      logic one_left;
      logic out_free;
   } status_type;

   // controller states, one-hot
   typedef enum logic [1:0] {
      ST_LOAD  = 2'b01,
      ST_DRAIN = 2'b10
   } state_type;

endpackage

>>> sv/edge_sort_by_weight.sv
// Stable ascending sort of a list of weighted edges. Edges enter one beat per
// cycle while loading; each is dropped into place in a chain of MAX_EDGES
// compare-and-shift cells, after every stored edge of equal or smaller weight.
// The beat marked is_last closes the list, and req_stall then stays high while
// the chain shifts its contents out through the output register, one result
// beat per cycle when rsp_stall is low, the last one flagged by out_last.
// Edges beyond MAX_EDGES are dropped, and overflowed is set on every result
// of that list; vertex indices pass through unchanged.
module edge_sort_by_weight
   import esw_pkg::*;
#(
   parameter int MAX_EDGES = MaxEdgesDefault
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;

   esw_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_last  (req_data.is_last),
      .status    (status),
      .cmd       (cmd),
      .req_stall (req_stall)
   );

   esw_datapath #(
      .MAX_EDGES (MAX_EDGES)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .status    (status),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   // no insert into a full chain
   a_no_insert_full: assert property (@(posedge clock) disable iff (reset)
      status.full |-> !cmd.insert)
      else $error("insert into full chain");

   // never pop an empty chain
   a_pop_nonempty: assert property (@(posedge clock) disable iff (reset)
      cmd.pop |-> status.has_entry)
      else $error("pop from empty chain");

   // a stalled result beat stays valid and unchanged
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_data)))
      else $error("stalled result beat changed");

endmodule

>>> sv/esw_datapath.sv
module esw_datapath
   import esw_pkg::*;
#(
   parameter int MAX_EDGES = MaxEdgesDefault
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output rsp_type    rsp_data
);

   entry_type                cell_ff [MAX_EDGES];
   entry_type                cell_in [MAX_EDGES];
   logic [MAX_EDGES-1:0]     valid_ff;
   logic [MAX_EDGES-1:0]     valid_in;
   logic [MAX_EDGES-1:0]     gt;
   logic                     ovf_ff;
   logic                     ovf_in;
   logic                     rsp_valid_ff;
   logic                     rsp_valid_in;
   rsp_type                  rsp_data_ff;
   rsp_type                  rsp_data_in;
   entry_type                new_entry;

   assign new_entry = '{src:    req_data.source_vertex,
                        dst:    req_data.dest_vertex,
                        weight: req_data.edge_weight};

   // insertion chain: on insert, cells heavier than the new edge move up one place; on pop, all move down one
   for (genvar i = 0; i < MAX_EDGES; i++) begin : g_cell
      assign gt[i] = !valid_ff[i] || (cell_ff[i].weight > req_data.edge_weight);

      if (i == 0) begin : g_head
         always_comb begin
            cell_in[i]  = cell_ff[i];
            valid_in[i] = valid_ff[i];
            if (cmd.insert) begin
               if (gt[i]) cell_in[i] = new_entry;
               valid_in[i] = 1'b1;
            end else if (cmd.pop) begin
               cell_in[i]  = cell_ff[i+1];
               valid_in[i] = valid_ff[i+1];
            end
         end
      end else if (i == MAX_EDGES - 1) begin : g_tail
         always_comb begin
            cell_in[i]  = cell_ff[i];
            valid_in[i] = valid_ff[i];
            if (cmd.insert) begin
               if (gt[i]) cell_in[i] = gt[i-1] ? cell_ff[i-1] : new_entry;
               valid_in[i] = valid_ff[i] | valid_ff[i-1];
            end else if (cmd.pop) begin
               valid_in[i] = 1'b0;
            end
         end
      end else begin : g_mid
         always_comb begin
            cell_in[i]  = cell_ff[i];
            valid_in[i] = valid_ff[i];
            if (cmd.insert) begin
               if (gt[i]) cell_in[i] = gt[i-1] ? cell_ff[i-1] : new_entry;
               valid_in[i] = valid_ff[i] | valid_ff[i-1];
            end else if (cmd.pop) begin
               cell_in[i]  = cell_ff[i+1];
               valid_in[i] = valid_ff[i+1];
            end
         end
      end
   end

   // status toward the controller
   always_comb begin
      status.full      = valid_ff[MAX_EDGES-1];
      status.has_entry = valid_ff[0];
      status.one_left  = valid_ff[0] && !valid_ff[1];
      status.out_free  = !rsp_valid_ff || !rsp_stall;
   end

   // overflow flag and output register
   always_comb begin
      ovf_in       = ovf_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (cmd.set_ovf) ovf_in = 1'b1;
      if (cmd.pop) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = '{out_source: cell_ff[0].src,
                          out_dest:   cell_ff[0].dst,
                          out_weight: cell_ff[0].weight,
                          out_last:   status.one_left,
                          overflowed: ovf_ff};
         if (status.one_left) ovf_in = 1'b0;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff     <= '0;
         ovf_ff       <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         valid_ff     <= valid_in;
         ovf_ff       <= ovf_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      cell_ff     <= cell_in;
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

>>> sv/esw_ctrl.sv
module esw_ctrl
   import esw_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_last,
   input  status_type status,
   output cmd_type    cmd,
   output logic       req_stall
);

   state_type state_ff;
   state_type state_in;

   // next state and commands
   always_comb begin
      state_in    = state_ff;
      cmd.insert  = 1'b0;
      cmd.set_ovf = 1'b0;
      cmd.pop     = 1'b0;
      unique case (state_ff)
         ST_LOAD: begin
            if (req_valid) begin
               cmd.insert  = !status.full;
               cmd.set_ovf = status.full;
               if (req_last) state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            if (status.out_free) begin
               cmd.pop = 1'b1;
               if (status.one_left) state_in = ST_LOAD;
            end
         end
         default: state_in = ST_LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_LOAD;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_LOAD);

endmodule
